@@ rtl/dbau_pkg.sv @@
// ----------------------------------------------------------------------------
// dbau_pkg
// Types and codes shared by the decimal BCD arithmetic unit and its digit ALU.
// ----------------------------------------------------------------------------
package dbau_pkg;

    localparam int DIGIT_W = 4;

    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_EXEC   = 2'd2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_NEG     = 2'd2;
    localparam logic [1:0] STATUS_DIVZERO = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_MUL,
        S_DSHIFT,
        S_DTRIAL,
        S_LOADW,
        S_LOADQ,
        S_LOADR,
        S_SKIP,
        S_EMIT,
        S_ERR
    } state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAC
    } alu_mode_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] carry;
    } alu_res_t;

endpackage

@@ rtl/dbau_digit_alu.sv @@
// ----------------------------------------------------------------------------
// dbau_digit_alu
// One decimal digit step: add with carry, subtract with borrow, or
// multiply-accumulate with a decimal carry out.
// ----------------------------------------------------------------------------
module dbau_digit_alu (
    input  dbau_pkg::alu_mode_t mode,
    input  logic [3:0]          a,
    input  logic [3:0]          b,
    input  logic [3:0]          pp,
    input  logic [3:0]          cin,
    output dbau_pkg::alu_res_t  res
);

    logic [4:0]  sum5;
    logic [4:0]  dif5;
    logic [7:0]  mac8;
    logic [15:0] recip;
    logic [3:0]  quo;

    always_comb begin
        sum5  = 5'(a) + 5'(b) + 5'(cin[0]);
        dif5  = 5'(a) + 5'd10 - 5'(b) - 5'(cin[0]);
        mac8  = 8'(a) * 8'(b) + 8'(pp) + 8'(cin);
        recip = 16'(mac8) * 16'd205;
        quo   = recip[14:11];
        res   = '0;
        case (mode)
            dbau_pkg::ALU_ADD: begin
                if (sum5 >= 5'd10) begin
                    res.digit = 4'(sum5 - 5'd10);
                    res.carry = 4'd1;
                end else begin
                    res.digit = sum5[3:0];
                end
            end
            dbau_pkg::ALU_SUB: begin
                if (dif5 >= 5'd10) begin
                    res.digit = 4'(dif5 - 5'd10);
                end else begin
                    res.digit = dif5[3:0];
                    res.carry = 4'd1;
                end
            end
            dbau_pkg::ALU_MAC: begin
                res.digit = 4'(mac8 - 8'(quo) * 8'd10);
                res.carry = quo;
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

@@ rtl/decimal_bcd_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// decimal_bcd_arithmetic_unit
// Unsigned BCD add, subtract, multiply and divide on digit-serial operands.
// ----------------------------------------------------------------------------
// Operand digits are loaded most significant first, one transfer per cycle.
// An execute transfer starts the operation, which runs one digit per cycle
// through a single digit ALU. Each result part is then scanned out of a
// 2*MAX_DIGITS+2 digit shift register, leading zeros skipped; a digit waits
// while the output register holds one that is not yet taken. No new
// transfer is taken until the last result digit has been handed to the
// output register.
// ----------------------------------------------------------------------------
module decimal_bcd_arithmetic_unit #(
    parameter int MAX_DIGITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // digit [3:0], op [5:4]
    input  logic [1:0] s_tuser,   // func [1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // result_digit [3:0]
    output logic [2:0] m_tuser,   // part [0], status [2:1]
    output logic       m_tlast
);

    localparam int WLEN = 2 * MAX_DIGITS + 2;
    localparam int ND   = MAX_DIGITS + 1;
    localparam int LW   = $clog2(MAX_DIGITS + 1);
    localparam int CW   = $clog2(WLEN);
    localparam int OW   = $clog2(MAX_DIGITS);
    localparam int RW   = $clog2(WLEN + 1);

    dbau_pkg::state_t state_reg, state_next;

    logic [MAX_DIGITS-1:0][3:0] a_reg, b_reg, q_reg;
    logic [WLEN-1:0][3:0]       w_reg, e_reg;
    logic [ND-1:0][3:0]         r_reg, d_reg;
    logic [LW-1:0]              len_a_reg, len_b_reg;
    logic                       ovf_reg;
    logic                       bad_a_reg, bad_b_reg, lz_a_reg, lz_b_reg, nz_b_reg;
    logic [1:0]                 op_reg, err_reg;
    logic [CW-1:0]              cnt_reg;
    logic [OW-1:0]              outer_reg;
    logic [RW-1:0]              rem_reg;
    logic                       part_reg, fin_reg;
    logic [3:0]                 carry_reg, pprev_reg, qd_reg;

    logic                       m_valid_reg, m_part_reg, m_last_reg;
    logic [3:0]                 m_digit_reg;
    logic [1:0]                 m_status_reg;

    logic [1:0] s_func, s_op;
    logic [3:0] s_digit;
    logic       in_acc, out_ok, out_push, out_part, out_last;
    logic [3:0] out_digit;
    logic [1:0] out_status;
    logic       a_ok, b_ok, exec_ok, e_zero, cnt_low;
    logic       last_w, last_d, last_o;

    dbau_pkg::alu_mode_t alu_mode;
    logic [3:0]          alu_a, alu_b, alu_pp;
    dbau_pkg::alu_res_t  alu_res;

    dbau_digit_alu u_alu (
        .mode (alu_mode),
        .a    (alu_a),
        .b    (alu_b),
        .pp   (alu_pp),
        .cin  (carry_reg),
        .res  (alu_res)
    );

    assign s_func  = s_tuser;
    assign s_digit = s_tdata[3:0];
    assign s_op    = s_tdata[5:4];
    assign in_acc  = s_tvalid && s_tready;
    assign out_ok  = !m_valid_reg || m_tready;

    assign a_ok    = (len_a_reg != '0) && !bad_a_reg && !(lz_a_reg && len_a_reg > LW'(1));
    assign b_ok    = (len_b_reg != '0) && !bad_b_reg && !(lz_b_reg && len_b_reg > LW'(1));
    assign exec_ok = a_ok && b_ok && !ovf_reg;
    assign e_zero  = (e_reg[WLEN-1] == 4'd0) && (rem_reg > RW'(1));
    assign cnt_low = cnt_reg < CW'(MAX_DIGITS);
    assign last_w  = cnt_reg == CW'(WLEN - 1);
    assign last_d  = cnt_reg == CW'(ND - 1);
    assign last_o  = outer_reg == OW'(MAX_DIGITS - 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dbau_pkg::S_IDLE: begin
                if (in_acc && s_func == dbau_pkg::FUNC_EXEC) begin
                    if (!exec_ok) begin
                        state_next = dbau_pkg::S_ERR;
                    end else begin
                        case (s_op)
                            dbau_pkg::OP_ADD: state_next = dbau_pkg::S_ADD;
                            dbau_pkg::OP_SUB: state_next = dbau_pkg::S_ADD;
                            dbau_pkg::OP_MUL: state_next = dbau_pkg::S_MUL;
                            default: state_next = nz_b_reg ? dbau_pkg::S_DSHIFT
                                                           : dbau_pkg::S_ERR;
                        endcase
                    end
                end
            end
            dbau_pkg::S_ADD: begin
                if (last_w) begin
                    state_next = (op_reg == dbau_pkg::OP_SUB && alu_res.carry[0])
                               ? dbau_pkg::S_ERR : dbau_pkg::S_LOADW;
                end
            end
            dbau_pkg::S_MUL: begin
                if (last_w && last_o) begin
                    state_next = dbau_pkg::S_LOADW;
                end
            end
            dbau_pkg::S_DSHIFT: state_next = dbau_pkg::S_DTRIAL;
            dbau_pkg::S_DTRIAL: begin
                if (last_d && alu_res.carry[0]) begin
                    state_next = last_o ? dbau_pkg::S_LOADQ : dbau_pkg::S_DSHIFT;
                end
            end
            dbau_pkg::S_LOADW: state_next = dbau_pkg::S_SKIP;
            dbau_pkg::S_LOADQ: state_next = dbau_pkg::S_SKIP;
            dbau_pkg::S_LOADR: state_next = dbau_pkg::S_SKIP;
            dbau_pkg::S_SKIP: begin
                if (!e_zero) begin
                    state_next = dbau_pkg::S_EMIT;
                end
            end
            dbau_pkg::S_EMIT: begin
                if (out_ok && rem_reg == RW'(1)) begin
                    state_next = fin_reg ? dbau_pkg::S_IDLE : dbau_pkg::S_LOADR;
                end
            end
            dbau_pkg::S_ERR: begin
                if (out_ok) begin
                    state_next = dbau_pkg::S_IDLE;
                end
            end
            default: state_next = dbau_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = state_reg == dbau_pkg::S_IDLE;
        out_push   = 1'b0;
        out_digit  = e_reg[WLEN-1];
        out_part   = part_reg;
        out_status = dbau_pkg::STATUS_OK;
        out_last   = fin_reg && rem_reg == RW'(1);
        alu_mode   = dbau_pkg::ALU_ADD;
        alu_a      = 4'd0;
        alu_b      = 4'd0;
        alu_pp     = 4'd0;
        case (state_reg)
            dbau_pkg::S_ADD: begin
                alu_mode = (op_reg == dbau_pkg::OP_SUB) ? dbau_pkg::ALU_SUB
                                                        : dbau_pkg::ALU_ADD;
                alu_a    = a_reg[0];
                alu_b    = b_reg[0];
            end
            dbau_pkg::S_MUL: begin
                alu_mode = dbau_pkg::ALU_MAC;
                alu_a    = cnt_low ? a_reg[0] : 4'd0;
                alu_b    = b_reg[MAX_DIGITS-1];
                alu_pp   = pprev_reg;
            end
            dbau_pkg::S_DTRIAL: begin
                alu_mode = dbau_pkg::ALU_SUB;
                alu_a    = r_reg[0];
                alu_b    = cnt_low ? b_reg[0] : 4'd0;
            end
            dbau_pkg::S_EMIT: begin
                out_push = out_ok;
            end
            dbau_pkg::S_ERR: begin
                out_push   = out_ok;
                out_digit  = 4'd0;
                out_part   = 1'b0;
                out_status = err_reg;
                out_last   = 1'b1;
            end
            default: begin
                out_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dbau_pkg::S_IDLE;
            a_reg       <= '0;
            b_reg       <= '0;
            len_a_reg   <= '0;
            len_b_reg   <= '0;
            ovf_reg     <= 1'b0;
            bad_a_reg   <= 1'b0;
            bad_b_reg   <= 1'b0;
            lz_a_reg    <= 1'b0;
            lz_b_reg    <= 1'b0;
            nz_b_reg    <= 1'b0;
            op_reg      <= dbau_pkg::OP_ADD;
            err_reg     <= dbau_pkg::STATUS_OK;
            cnt_reg     <= '0;
            outer_reg   <= '0;
            rem_reg     <= '0;
            part_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                dbau_pkg::S_IDLE: begin
                    if (in_acc) begin
                        case (s_func)
                            dbau_pkg::FUNC_LOAD_A: begin
                                if (len_a_reg == LW'(MAX_DIGITS)) begin
                                    ovf_reg <= 1'b1;
                                end else begin
                                    a_reg     <= {a_reg[MAX_DIGITS-2:0], s_digit};
                                    len_a_reg <= len_a_reg + LW'(1);
                                    if (len_a_reg == '0) begin
                                        lz_a_reg <= s_digit == 4'd0;
                                    end
                                    if (s_digit > 4'd9) begin
                                        bad_a_reg <= 1'b1;
                                    end
                                end
                            end
                            dbau_pkg::FUNC_LOAD_B: begin
                                if (len_b_reg == LW'(MAX_DIGITS)) begin
                                    ovf_reg <= 1'b1;
                                end else begin
                                    b_reg     <= {b_reg[MAX_DIGITS-2:0], s_digit};
                                    len_b_reg <= len_b_reg + LW'(1);
                                    if (len_b_reg == '0) begin
                                        lz_b_reg <= s_digit == 4'd0;
                                    end
                                    if (s_digit > 4'd9) begin
                                        bad_b_reg <= 1'b1;
                                    end
                                    if (s_digit != 4'd0) begin
                                        nz_b_reg <= 1'b1;
                                    end
                                end
                            end
                            dbau_pkg::FUNC_EXEC: begin
                                op_reg    <= s_op;
                                err_reg   <= exec_ok ? dbau_pkg::STATUS_DIVZERO
                                                     : dbau_pkg::STATUS_INVALID;
                                len_a_reg <= '0;
                                len_b_reg <= '0;
                                ovf_reg   <= 1'b0;
                                bad_a_reg <= 1'b0;
                                bad_b_reg <= 1'b0;
                                lz_a_reg  <= 1'b0;
                                lz_b_reg  <= 1'b0;
                                nz_b_reg  <= 1'b0;
                                cnt_reg   <= '0;
                                outer_reg <= '0;
                            end
                            default: begin
                                ovf_reg <= ovf_reg;
                            end
                        endcase
                    end
                end
                dbau_pkg::S_ADD: begin
                    a_reg   <= {4'd0, a_reg[MAX_DIGITS-1:1]};
                    b_reg   <= {4'd0, b_reg[MAX_DIGITS-1:1]};
                    cnt_reg <= cnt_reg + CW'(1);
                    err_reg <= dbau_pkg::STATUS_NEG;
                end
                dbau_pkg::S_MUL: begin
                    if (cnt_low) begin
                        a_reg <= {a_reg[0], a_reg[MAX_DIGITS-1:1]};
                    end
                    if (last_w) begin
                        cnt_reg   <= '0;
                        outer_reg <= outer_reg + OW'(1);
                        b_reg     <= {b_reg[MAX_DIGITS-2:0], 4'd0};
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                dbau_pkg::S_DSHIFT: begin
                    a_reg   <= {a_reg[MAX_DIGITS-2:0], 4'd0};
                    cnt_reg <= '0;
                end
                dbau_pkg::S_DTRIAL: begin
                    if (cnt_low) begin
                        b_reg <= {b_reg[0], b_reg[MAX_DIGITS-1:1]};
                    end
                    if (last_d) begin
                        cnt_reg <= '0;
                        if (alu_res.carry[0]) begin
                            outer_reg <= outer_reg + OW'(1);
                        end
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                dbau_pkg::S_LOADW: begin
                    rem_reg  <= RW'(WLEN);
                    part_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
                dbau_pkg::S_LOADQ: begin
                    rem_reg  <= RW'(WLEN);
                    part_reg <= 1'b0;
                    fin_reg  <= 1'b0;
                end
                dbau_pkg::S_LOADR: begin
                    rem_reg  <= RW'(WLEN);
                    part_reg <= 1'b1;
                    fin_reg  <= 1'b1;
                end
                dbau_pkg::S_SKIP: begin
                    if (e_zero) begin
                        rem_reg <= rem_reg - RW'(1);
                    end
                end
                dbau_pkg::S_EMIT: begin
                    if (out_ok) begin
                        rem_reg <= rem_reg - RW'(1);
                    end
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            if (state_reg != dbau_pkg::S_IDLE && state_next == dbau_pkg::S_IDLE) begin
                a_reg <= '0;
                b_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_push) begin
            m_digit_reg  <= out_digit;
            m_part_reg   <= out_part;
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
        end
        case (state_reg)
            dbau_pkg::S_IDLE: begin
                if (in_acc && s_func == dbau_pkg::FUNC_EXEC) begin
                    w_reg     <= '0;
                    r_reg     <= '0;
                    q_reg     <= '0;
                    carry_reg <= 4'd0;
                    pprev_reg <= 4'd0;
                end
            end
            dbau_pkg::S_ADD: begin
                w_reg     <= {alu_res.digit, w_reg[WLEN-1:1]};
                carry_reg <= alu_res.carry;
            end
            dbau_pkg::S_MUL: begin
                w_reg <= {alu_res.digit, w_reg[WLEN-1:1]};
                if (last_w) begin
                    carry_reg <= 4'd0;
                    pprev_reg <= 4'd0;
                end else begin
                    carry_reg <= alu_res.carry;
                    pprev_reg <= w_reg[0];
                end
            end
            dbau_pkg::S_DSHIFT: begin
                r_reg     <= {r_reg[ND-2:0], a_reg[MAX_DIGITS-1]};
                qd_reg    <= 4'd0;
                carry_reg <= 4'd0;
            end
            dbau_pkg::S_DTRIAL: begin
                d_reg <= {alu_res.digit, d_reg[ND-1:1]};
                if (last_d) begin
                    carry_reg <= 4'd0;
                    if (alu_res.carry[0]) begin
                        q_reg <= {q_reg[MAX_DIGITS-2:0], qd_reg};
                        r_reg <= {r_reg[0], r_reg[ND-1:1]};
                    end else begin
                        r_reg  <= {alu_res.digit, d_reg[ND-1:1]};
                        qd_reg <= qd_reg + 4'd1;
                    end
                end else begin
                    carry_reg <= alu_res.carry;
                    r_reg     <= {r_reg[0], r_reg[ND-1:1]};
                end
            end
            dbau_pkg::S_LOADW: begin
                e_reg <= w_reg;
            end
            dbau_pkg::S_LOADQ: begin
                e_reg <= {{((WLEN - MAX_DIGITS) * 4){1'b0}}, q_reg};
            end
            dbau_pkg::S_LOADR: begin
                e_reg <= {{((WLEN - ND) * 4){1'b0}}, r_reg};
            end
            dbau_pkg::S_SKIP: begin
                if (e_zero) begin
                    e_reg <= {e_reg[WLEN-2:0], 4'd0};
                end
            end
            dbau_pkg::S_EMIT: begin
                if (out_ok) begin
                    e_reg <= {e_reg[WLEN-2:0], 4'd0};
                end
            end
            default: begin
                e_reg <= e_reg;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_digit_reg};
    assign m_tuser  = {m_status_reg, m_part_reg};
    assign m_tlast  = m_last_reg;

endmodule
